// File: src/clrle_pkg.sv
// Shared types, constants and helper functions of the code-length run-length encoder.
package clrle_pkg;

   localparam int LENGTH_W = 4;
   localparam int SYMBOL_W = 5;
   localparam int EXTRA_W  = 7;
   localparam int PREV_W   = 5;
   localparam int ZERO_W   = 8;
   localparam int REPEAT_W = 3;
   localparam int GROUP_N  = 3;
   localparam int COUNT_W  = 2;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [PREV_W-1:0]   NO_PREVIOUS    = 5'd31;
   localparam logic [ZERO_W-1:0]   ZERO_RUN_MAX   = 8'd138;
   localparam logic [ZERO_W-1:0]   SHORT_ZERO_MAX = 8'd10;
   localparam logic [REPEAT_W-1:0] REPEAT_MAX     = 3'd6;
   localparam logic [SYMBOL_W-1:0] SYM_REPEAT     = 5'd16;
   localparam logic [SYMBOL_W-1:0] SYM_SHORT_ZERO = 5'd17;
   localparam logic [SYMBOL_W-1:0] SYM_LONG_ZERO  = 5'd18;

   // Up to two symbols released by flushing one pending run.
   typedef struct packed {
      logic [COUNT_W-1:0]             count;
      logic [1:0][SYMBOL_W-1:0]       symbol;
      logic [1:0][EXTRA_W-1:0]        extra;
   } burst_type;

   // All symbols caused by one input item, oldest in slot 0.
   typedef struct packed {
      logic [COUNT_W-1:0]             count;
      logic [GROUP_N-1:0][SYMBOL_W-1:0] symbol;
      logic [GROUP_N-1:0][EXTRA_W-1:0]  extra;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic burst_type single_burst(input logic [SYMBOL_W-1:0] sym,
                                              input logic [EXTRA_W-1:0] ext);
      burst_type b;
      b           = '0;
      b.count     = 2'd1;
      b.symbol[0] = sym;
      b.extra[0]  = ext;
      return b;
   endfunction

   function automatic burst_type repeat_burst(input logic [REPEAT_W-1:0] run,
                                              input logic [PREV_W-1:0] prev);
      burst_type b;
      b = '0;
      if (run != '0) begin
         if (run < 3'd3) begin
            // Short repeats go out as literal copies of the previous length.
            b.count     = run[COUNT_W-1:0];
            b.symbol[0] = prev;
            b.symbol[1] = prev;
         end else begin
            b = single_burst(SYM_REPEAT, EXTRA_W'(run - 3'd3));
         end
      end
      return b;
   endfunction

   function automatic burst_type zero_burst(input logic [ZERO_W-1:0] run);
      burst_type b;
      b = '0;
      if (run != '0) begin
         if (run < 8'd3) begin
            b.count = run[COUNT_W-1:0];
         end else if (run <= SHORT_ZERO_MAX) begin
            b = single_burst(SYM_SHORT_ZERO, EXTRA_W'(run - 8'd3));
         end else begin
            b = single_burst(SYM_LONG_ZERO, EXTRA_W'(run - 8'd11));
         end
      end
      return b;
   endfunction

   function automatic group_type append_burst(input group_type g, input burst_type b);
      group_type r;
      r = g;
      for (int i = 0; i < 2; i++) begin
         if ((b.count > COUNT_W'(i)) && (r.count != COUNT_W'(GROUP_N))) begin
            r.symbol[r.count] = b.symbol[i];
            r.extra[r.count]  = b.extra[i];
            r.count           = r.count + 2'd1;
         end
      end
      return r;
   endfunction

endpackage

// File: src/clrle_front.sv
// Front end: run state and classification of each code length into a group of symbols.
module clrle_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [clrle_pkg::LENGTH_W-1:0]      req_code_length,
   input  logic                                req_end_of_table,
   input  clrle_pkg::queue_status_type         q_status,
   output logic                                q_push,
   output clrle_pkg::group_type                q_wr_data
);
   import clrle_pkg::*;

   logic [PREV_W-1:0]   prev_ff, prev_in;
   logic [ZERO_W-1:0]   zero_ff, zero_in;
   logic [REPEAT_W-1:0] repeat_ff, repeat_in;
   logic [PREV_W-1:0]   length_ext;
   logic                accept;
   group_type           group;

   assign req_full   = q_status.full;
   assign accept     = req_push && !q_status.full;
   assign length_ext = {1'b0, req_code_length};

   always_comb begin
      group     = '0;
      zero_in   = zero_ff;
      repeat_in = repeat_ff;
      prev_in   = length_ext;
      if (req_code_length == '0) begin
         group     = append_burst(group, repeat_burst(repeat_ff, prev_ff));
         repeat_in = '0;
         zero_in   = zero_ff + 8'd1;
         if (zero_in == ZERO_RUN_MAX) begin
            group   = append_burst(group, zero_burst(zero_in));
            zero_in = '0;
         end
      end else begin
         group   = append_burst(group, zero_burst(zero_ff));
         zero_in = '0;
         if (length_ext != prev_ff) begin
            group     = append_burst(group, repeat_burst(repeat_ff, prev_ff));
            repeat_in = '0;
            group     = append_burst(group, single_burst(length_ext, '0));
         end else begin
            repeat_in = repeat_ff + 3'd1;
            if (repeat_in == REPEAT_MAX) begin
               group     = append_burst(group,
                              single_burst(SYM_REPEAT, EXTRA_W'(REPEAT_MAX - 3'd3)));
               repeat_in = '0;
            end
         end
      end
      // The end of a table flushes whichever run is still open and starts afresh.
      if (req_end_of_table) begin
         if (repeat_in != '0) begin
            group = append_burst(group, repeat_burst(repeat_in, prev_in));
         end else begin
            group = append_burst(group, zero_burst(zero_in));
         end
         prev_in   = NO_PREVIOUS;
         zero_in   = '0;
         repeat_in = '0;
      end
   end

   assign q_push    = accept && (group.count != '0);
   assign q_wr_data = group;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= NO_PREVIOUS;
         zero_ff   <= '0;
         repeat_ff <= '0;
      end else if (accept) begin
         prev_ff   <= prev_in;
         zero_ff   <= zero_in;
         repeat_ff <= repeat_in;
      end
   end

endmodule

// File: src/clrle_queue.sv
// Short queue of symbol groups between the front end and the back end.
module clrle_queue #(
   parameter int QUEUE_DEPTH = clrle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_push,
   input  clrle_pkg::group_type          q_wr_data,
   input  logic                          q_pop,
   output clrle_pkg::group_type          q_rd_data,
   output clrle_pkg::queue_status_type   q_status
);
   import clrle_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   group_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = q_push && !q_status.full;
   assign do_pop         = q_pop && !q_status.empty;
   assign q_rd_data      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= q_wr_data;
      end
   end

endmodule

// File: src/clrle_back.sv
// Back end: holds one symbol group and sends its symbols out one per transaction.
module clrle_back (
   input  logic                               clock,
   input  logic                               reset,
   input  clrle_pkg::group_type               q_rd_data,
   input  clrle_pkg::queue_status_type        q_status,
   output logic                               q_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [clrle_pkg::SYMBOL_W-1:0]     rsp_symbol,
   output logic [clrle_pkg::EXTRA_W-1:0]      rsp_extra,
   output logic                               rsp_last_of_item
);
   import clrle_pkg::*;

   group_type          entry_ff;
   logic               valid_ff, valid_in;
   logic [COUNT_W-1:0] index_ff, index_in;
   logic               sent, finish, take;

   assign rsp_empty        = !valid_ff;
   assign rsp_last_of_item = (index_ff == entry_ff.count - 2'd1);
   assign rsp_symbol       = entry_ff.symbol[index_ff];
   assign rsp_extra        = entry_ff.extra[index_ff];

   assign sent   = valid_ff && rsp_pop;
   assign finish = sent && rsp_last_of_item;
   // A new group, if the queue holds one, is loaded in the same cycle as the last symbol of the old one leaves.
   assign take   = (!valid_ff || finish) && !q_status.empty;
   assign q_pop  = take;

   always_comb begin
      valid_in = valid_ff;
      index_in = index_ff;
      if (take) begin
         valid_in = 1'b1;
         index_in = '0;
      end else if (finish) begin
         valid_in = 1'b0;
      end else if (sent) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= q_rd_data;
      end
   end

endmodule

// File: src/code_length_run_length_encoder.sv
// Run-length encoder that turns a stream of code lengths into code-length alphabet symbols.
// The front end takes one code length per cycle whenever its queue has room and updates the
// pending zero and repeat runs in that same cycle; the one to three symbols an item causes are
// queued as a group, and while groups wait and rsp_pop is held the back end sends one symbol
// per cycle. An item thus occupies the single-symbol output port for as many symbols as it
// produces, one to three; an item that only extends a run produces nothing. The first symbol
// of a group is registered in the queue store and then in the back end's entry register
// before it appears on the result ports. The item flagged end_of_table flushes the open run
// and returns the front end's run state to its reset values.
module code_length_run_length_encoder #(
   parameter int QUEUE_DEPTH = clrle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [clrle_pkg::LENGTH_W-1:0]     req_code_length,
   input  logic                               req_end_of_table,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [clrle_pkg::SYMBOL_W-1:0]     rsp_symbol,
   output logic [clrle_pkg::EXTRA_W-1:0]      rsp_extra,
   output logic                               rsp_last_of_item
);
   import clrle_pkg::*;

   queue_status_type q_status;
   group_type        q_wr_data, q_rd_data;
   logic             q_push, q_pop;

   clrle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_length  (req_code_length),
      .req_end_of_table (req_end_of_table),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_wr_data        (q_wr_data)
   );

   clrle_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .q_wr_data (q_wr_data),
      .q_pop     (q_pop),
      .q_rd_data (q_rd_data),
      .q_status  (q_status)
   );

   clrle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_rd_data        (q_rd_data),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_symbol       (rsp_symbol),
      .rsp_extra        (rsp_extra),
      .rsp_last_of_item (rsp_last_of_item)
   );

   a_queue_status_consistent: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_push_fills_queue: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_status.empty)
      else $error("queued group lost");

   a_symbol_in_alphabet: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_symbol <= SYM_LONG_ZERO))
      else $error("symbol outside the code-length alphabet");

   a_literal_has_no_extra: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_symbol < SYM_REPEAT)) |-> (rsp_extra == '0))
      else $error("literal length carries extra bits");

endmodule
